/* rtl/cp1251tc_pkg.sv */
// cp1251tc_pkg: shared constants and the Windows-1251 high-half code table
// for the text check decoder; no dependencies
`default_nettype none

package cp1251tc_pkg;

  // default width of the kept NUL counter
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  localparam logic [7:0]  BYTE_NUL     = 8'h00;
  localparam logic [7:0]  BYTE_UNMAPPED = 8'h98;
  localparam logic [15:0] CODE_REPL    = 16'hFFFD;
  localparam logic [15:0] CODE_TAB     = 16'h0009;
  localparam logic [15:0] CODE_LF      = 16'h000A;
  localparam logic [15:0] CODE_VT      = 16'h000B;
  localparam logic [15:0] CODE_FF      = 16'h000C;
  localparam logic [15:0] CODE_CR      = 16'h000D;
  localparam logic [15:0] CODE_SPACE   = 16'h0020;
  localparam logic [15:0] CODE_NBSP    = 16'h00A0;

  // code units for bytes 0x80..0xFF, indexed by the low seven bits
  localparam logic [15:0] HIGH_MAP [0:127] = '{
    16'h0402,16'h0403,16'h201A,16'h0453,16'h201E,16'h2026,16'h2020,16'h2021,
    16'h20AC,16'h2030,16'h0409,16'h2039,16'h040A,16'h040C,16'h040B,16'h040F,
    16'h0452,16'h2018,16'h2019,16'h201C,16'h201D,16'h2022,16'h2013,16'h2014,
    16'hFFFD,16'h2122,16'h0459,16'h203A,16'h045A,16'h045C,16'h045B,16'h045F,
    16'h00A0,16'h040E,16'h045E,16'h0408,16'h00A4,16'h0490,16'h00A6,16'h00A7,
    16'h0401,16'h00A9,16'h0404,16'h00AB,16'h00AC,16'h00AD,16'h00AE,16'h0407,
    16'h00B0,16'h00B1,16'h0406,16'h0456,16'h0491,16'h00B5,16'h00B6,16'h00B7,
    16'h0451,16'h2116,16'h0454,16'h00BB,16'h0458,16'h0405,16'h0455,16'h0457,
    16'h0410,16'h0411,16'h0412,16'h0413,16'h0414,16'h0415,16'h0416,16'h0417,
    16'h0418,16'h0419,16'h041A,16'h041B,16'h041C,16'h041D,16'h041E,16'h041F,
    16'h0420,16'h0421,16'h0422,16'h0423,16'h0424,16'h0425,16'h0426,16'h0427,
    16'h0428,16'h0429,16'h042A,16'h042B,16'h042C,16'h042D,16'h042E,16'h042F,
    16'h0430,16'h0431,16'h0432,16'h0433,16'h0434,16'h0435,16'h0436,16'h0437,
    16'h0438,16'h0439,16'h043A,16'h043B,16'h043C,16'h043D,16'h043E,16'h043F,
    16'h0440,16'h0441,16'h0442,16'h0443,16'h0444,16'h0445,16'h0446,16'h0447,
    16'h0448,16'h0449,16'h044A,16'h044B,16'h044C,16'h044D,16'h044E,16'h044F
  };

endpackage

`default_nettype wire

/* rtl/cp1251tc_in_if.sv */
// cp1251tc_in_if: byte request channel of the text check decoder
// valid/ready handshake; no dependencies
`default_nettype none

interface cp1251tc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_in;

  modport source (output valid, output byte_in, output last_in, input ready);
  modport sink   (input valid, input byte_in, input last_in, output ready);
endinterface

`default_nettype wire

/* rtl/cp1251tc_out_if.sv */
// cp1251tc_out_if: result request channel of the text check decoder
// valid/ready handshake; no dependencies
`default_nettype none

interface cp1251tc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        byte_bad;
  logic        last_out;
  logic        text_valid;
  logic [15:0] trailing_nuls;

  modport source (output valid, output code_unit, output byte_bad, output last_out,
                  output text_valid, output trailing_nuls, input ready);
  modport sink   (input valid, input code_unit, input byte_bad, input last_out,
                  input text_valid, input trailing_nuls, output ready);
endinterface

`default_nettype wire

/* rtl/cp1251_text_check_decoder_core.sv */
// Path: an accepted request passes the input register, then the result register, to its result.
// Throughput: one byte per cycle while the result side is ready; the table lookup and flag update sit in one stage.
// Backpressure from the result side stalls both stages; ready follows the result register.
// Reset (rst_n, synchronous, active low) empties both stages and clears the string flags
// and the NUL counter; the flags are also cleared after every last byte.
`default_nettype none

module cp1251_text_check_decoder_core
  import cp1251tc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  cp1251tc_in_if.sink       in_ch,
  cp1251tc_out_if.source    out_ch
);

  // input stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // result stage
  logic        out_valid_r;
  logic [15:0] out_code_r;
  logic        out_bad_r;
  logic        out_last_r;
  logic        out_text_valid_r;
  logic [15:0] out_tn_r;

  // string state
  logic                   in_tail_r, in_tail_nxt;
  logic                   failed_r, failed_nxt;
  logic                   body_seen_r, body_seen_nxt;
  logic                   nonspace_seen_r, nonspace_seen_nxt;
  logic [COUNT_WIDTH-1:0] nul_count_r, nul_count_nxt;

  logic                   advance;
  logic                   step;
  logic [15:0]            cu;
  logic                   bad;
  logic                   is_space;
  logic                   ctrl_bad;
  logic                   verdict;
  logic [COUNT_WIDTH+15:0] count_ext;
  logic [15:0]            tn;

  // stage handshake
  assign advance      = !out_valid_r || out_ch.ready;
  assign step         = s1_valid_r && advance;
  assign in_ch.ready  = advance || !s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.byte_in;
      s1_last_r <= in_ch.last_in;
    end
  end

  // decode and character classes
  assign cu       = s1_byte_r[7] ? HIGH_MAP[s1_byte_r[6:0]] : {8'h00, s1_byte_r};
  assign bad      = (s1_byte_r == BYTE_UNMAPPED);
  assign is_space = (cu >= CODE_TAB && cu <= CODE_CR) || cu == CODE_SPACE || cu == CODE_NBSP;
  assign ctrl_bad = (cu < CODE_SPACE) && cu != CODE_TAB && cu != CODE_LF && cu != CODE_CR;

  // flag update for the current byte
  always_comb begin
    in_tail_nxt       = in_tail_r;
    failed_nxt        = failed_r;
    body_seen_nxt     = body_seen_r;
    nonspace_seen_nxt = nonspace_seen_r;
    nul_count_nxt     = nul_count_r;
    if (in_tail_r) begin
      if (s1_byte_r != BYTE_NUL) begin
        failed_nxt = 1'b1;
      end else if (nul_count_r != {COUNT_WIDTH{1'b1}}) begin
        nul_count_nxt = nul_count_r + 1'b1;
      end
    end else if (s1_byte_r == BYTE_NUL) begin
      in_tail_nxt   = 1'b1;
      nul_count_nxt = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    end else begin
      body_seen_nxt = 1'b1;
      if (bad || ctrl_bad) begin
        failed_nxt = 1'b1;
      end
      if (!is_space) begin
        nonspace_seen_nxt = 1'b1;
      end
    end
  end

  // verdict on the last byte
  assign verdict   = s1_last_r && !failed_nxt && body_seen_nxt && nonspace_seen_nxt;
  assign count_ext = {16'h0000, nul_count_nxt};
  assign tn        = verdict ? count_ext[15:0] : 16'h0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_tail_r       <= 1'b0;
      failed_r        <= 1'b0;
      body_seen_r     <= 1'b0;
      nonspace_seen_r <= 1'b0;
      nul_count_r     <= '0;
    end else if (step) begin
      if (s1_last_r) begin
        in_tail_r       <= 1'b0;
        failed_r        <= 1'b0;
        body_seen_r     <= 1'b0;
        nonspace_seen_r <= 1'b0;
        nul_count_r     <= '0;
      end else begin
        in_tail_r       <= in_tail_nxt;
        failed_r        <= failed_nxt;
        body_seen_r     <= body_seen_nxt;
        nonspace_seen_r <= nonspace_seen_nxt;
        nul_count_r     <= nul_count_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_code_r       <= cu;
      out_bad_r        <= bad;
      out_last_r       <= s1_last_r;
      out_text_valid_r <= verdict;
      out_tn_r         <= tn;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.code_unit     = out_code_r;
  assign out_ch.byte_bad      = out_bad_r;
  assign out_ch.last_out      = out_last_r;
  assign out_ch.text_valid    = out_text_valid_r;
  assign out_ch.trailing_nuls = out_tn_r;

  // checks
  a_verdict_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_text_valid_r) |-> out_last_r)
    else $error("verdict given on a byte that is not last");

  a_count_needs_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tn_r != 16'h0000) |-> out_text_valid_r)
    else $error("trailing NUL count given without a passing verdict");

  a_bad_gives_repl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> out_code_r == CODE_REPL)
    else $error("unmapped byte without replacement code unit");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step && s1_last_r) |=> (!in_tail_r && !failed_r && !body_seen_r && !nonspace_seen_r
                             && nul_count_r == '0))
    else $error("string state not cleared after last byte");

endmodule

`default_nettype wire
